@@ rtl/kda_pkg.sv @@
`default_nettype none
package kda_pkg;

  localparam int NUM_KEYS  = 16;
  localparam int CODE_W    = 6;
  localparam int OUT_W     = 7;
  localparam int COUNT_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_LONG = 2'd2;

  localparam logic [3:0] MIN_PRESS_RST   = 4'd2;
  localparam logic [4:0] LONG_PRESS_RST  = 5'd16;
  localparam logic [5:0] SINGLE_LONG_RST = 6'd32;

  localparam logic [CODE_W-1:0]  SHIFT_BIT   = 6'h20;
  localparam logic [OUT_W-1:0]   LONG_MARK   = 7'h40;
  localparam logic [COUNT_W-1:0] CYCLE_LOW   = 6'd33;
  localparam logic [COUNT_W-1:0] CYCLE_HIGH  = 6'd36;
  localparam logic [CODE_W-1:0]  FUNC_LOW    = 6'd3;
  localparam logic [CODE_W-1:0]  FUNC_HIGH   = 6'd8;

  typedef struct packed {
    logic [3:0] min_press_ticks;
    logic [4:0] long_press_ticks;
    logic [5:0] single_long_tick;
  } kda_cfg_t;

  typedef struct packed {
    logic             emit;
    logic [OUT_W-1:0] code;
  } kda_result_t;

  // Raw code of each key position, bit 0 first
  function automatic logic [CODE_W-1:0] key_code_of(input logic [3:0] idx);
    logic [CODE_W-1:0] c;
    unique case (idx)
      4'd0:  c = 6'h08;
      4'd1:  c = 6'h07;
      4'd2:  c = 6'h06;
      4'd3:  c = 6'h05;
      4'd4:  c = 6'h04;
      4'd5:  c = 6'h03;
      4'd6:  c = 6'h02;
      4'd7:  c = 6'h16;
      4'd8:  c = 6'h01;
      4'd9:  c = 6'h15;
      4'd10: c = 6'h12;
      4'd11: c = 6'h11;
      4'd12: c = 6'h14;
      4'd13: c = 6'h13;
      4'd14: c = 6'h17;
      4'd15: c = 6'h18;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/kda_encoder.sv @@
`default_nettype none
module kda_encoder (
  input  wire logic [kda_pkg::NUM_KEYS-1:0]  keys,
  input  wire logic                          shift,
  output logic      [kda_pkg::CODE_W-1:0]    code
);
  import kda_pkg::*;

  logic [CODE_W-1:0] raw;

  // Highest set bit wins: later iterations override earlier ones
  always_comb begin
    raw = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (keys[i]) begin
        raw = key_code_of(4'(i));
      end
    end
  end

  assign code = (raw != '0 && shift) ? (raw | SHIFT_BIT) : raw;

endmodule
`default_nettype wire

@@ rtl/kda_step.sv @@
`default_nettype none
module kda_step (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic [kda_pkg::CODE_W-1:0]  code,
  input  wire logic                        show,
  input  wire kda_pkg::kda_cfg_t           cfg,
  output kda_pkg::kda_result_t             res
);
  import kda_pkg::*;

  logic               held_r, held_nxt;
  logic               pend_r, pend_nxt;
  logic [CODE_W-1:0]  cur_r, cur_nxt;
  logic [CODE_W-1:0]  rel_r, rel_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] cnt_inc;
  logic               repeat_tick;
  logic               is_func;

  assign cnt_inc     = (cnt_r >= CYCLE_HIGH) ? CYCLE_LOW : cnt_r + 6'd1;
  assign repeat_tick = (cnt_inc > {1'b0, cfg.long_press_ticks}) && (cnt_inc[1:0] == 2'b00);
  assign is_func     = (code >= FUNC_LOW) && (code <= FUNC_HIGH);

  always_comb begin
    held_nxt = held_r;
    pend_nxt = pend_r;
    cur_nxt  = cur_r;
    rel_nxt  = rel_r;
    cnt_nxt  = cnt_r;
    res      = '0;
    if (held_r) begin
      if (code == cur_r) begin
        cnt_nxt = cnt_inc;
        if (repeat_tick) begin
          if (is_func) begin
            // if shown, function keys fire only at single_long_tick
            if (!show || cnt_inc == cfg.single_long_tick) begin
              res.emit = 1'b1;
              res.code = {1'b0, code} | LONG_MARK;
            end
          end else begin
            res.emit = 1'b1;
            res.code = {1'b0, code};
          end
        end
      end else begin
        if (code == '0) begin
          // drop releases that are too short or too long
          if (cnt_r >= {1'b0, cfg.long_press_ticks} ||
              cnt_r < {2'b00, cfg.min_press_ticks}) begin
            held_nxt = 1'b0;
          end else begin
            rel_nxt  = cur_r;
            pend_nxt = 1'b1;
          end
        end else begin
          cur_nxt = code;
        end
        cnt_nxt = '0;
      end
    end else if (code != '0) begin
      cur_nxt  = code;
      held_nxt = 1'b1;
      cnt_nxt  = '0;
    end

    if (held_nxt && pend_nxt && rel_nxt != '0 && !res.emit) begin
      held_nxt = 1'b0;
      pend_nxt = 1'b0;
      res.emit = 1'b1;
      res.code = {1'b0, rel_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      pend_r <= 1'b0;
      cur_r  <= '0;
      rel_r  <= '0;
      cnt_r  <= '0;
    end else if (adv) begin
      held_r <= held_nxt;
      pend_r <= pend_nxt;
      cur_r  <= cur_nxt;
      rel_r  <= rel_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/keypad_debounce_autorepeat.sv @@
// Keypad debounce and auto-repeat.
// Input channel (in_valid/in_stall): one transaction per scan tick carrying
// the 16-key pressed map, the shift key and the display show state.
// Result channel (out_valid/out_stall): zero or one key code per tick; bit 5
// marks shift, bit 6 marks a long press of a function key.
// Config channel (cfg_valid/cfg_ready): index 0 min press ticks, 1 long press
// ticks, 2 single long tick; ready is always high, write only while idle.
// A tick taken into the input register is stepped through the encoder and
// hold tracker, and any result it yields is loaded into the output register.
// Throughput: one tick per cycle unless the receiver stalls with a result
// pending, set by the state update of the hold tracker.
// Reset clears the hold state and both pipeline registers and loads the
// default config. When the receiver stalls with a result pending, the input
// register holds and in_stall rises; ticks with no result still pass.
`default_nettype none
module keypad_debounce_autorepeat (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [kda_pkg::NUM_KEYS-1:0]     in_keys_pressed,
  input  wire logic                             in_shift_pressed,
  input  wire logic                             in_lcd_show_state,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [kda_pkg::OUT_W-1:0]        out_key_code,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [kda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kda_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import kda_pkg::*;

  kda_cfg_t              cfg_r;
  logic                  s1_valid_r;
  logic [NUM_KEYS-1:0]   s1_keys_r;
  logic                  s1_shift_r;
  logic                  s1_show_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_code_r;
  logic [CODE_W-1:0]     code;
  kda_result_t           res;
  logic                  out_free;
  logic                  s1_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_press_ticks  <= MIN_PRESS_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
      cfg_r.single_long_tick <= SINGLE_LONG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_PRESS:   cfg_r.min_press_ticks  <= cfg_data[3:0];
        REG_LONG_PRESS:  cfg_r.long_press_ticks <= cfg_data[4:0];
        REG_SINGLE_LONG: cfg_r.single_long_tick <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output slot can load when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (out_free || !res.emit);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_keys_r  <= in_keys_pressed;
      s1_shift_r <= in_shift_pressed;
      s1_show_r  <= in_lcd_show_state;
    end
  end

  kda_encoder u_encoder (
    .keys  (s1_keys_r),
    .shift (s1_shift_r),
    .code  (code)
  );

  kda_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .code  (code),
    .show  (s1_show_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_code_r <= res.code;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = out_code_r;

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import kda_pkg::*;

  typedef struct packed {
    logic [NUM_KEYS-1:0]  keys;
    logic                 shift;
    logic                 show;
  } scan_tick_t;

  // Raw code per key position, bit 0 first; bit 15 wins.
  localparam logic [CODE_W-1:0] KEY_MAP [NUM_KEYS] = '{
    6'h08, 6'h07, 6'h06, 6'h05, 6'h04, 6'h03, 6'h02, 6'h16,
    6'h01, 6'h15, 6'h12, 6'h11, 6'h14, 6'h13, 6'h17, 6'h18
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [NUM_KEYS-1:0]   in_keys_pressed = '0;
  logic                  in_shift_pressed = 1'b0;
  logic                  in_lcd_show_state = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_W-1:0]      out_key_code;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_data = '0;

  // Pending scan ticks and the key codes they are predicted to emit
  scan_tick_t       tick_q[$];
  logic [OUT_W-1:0] code_q[$];
  scan_tick_t       next_tick;

  int unsigned ticks_pushed = 0;
  int unsigned ticks_taken = 0;
  int unsigned codes_seen = 0;
  int unsigned settings_cnt = 1;
  int unsigned fail_cnt = 0;

  int unsigned hold_off_left = 0;
  logic        hold_off_done = 1'b0;
  logic        quiet;

  // Predictor state and register copies
  logic [3:0]         min_ticks = MIN_PRESS_RST;
  logic [4:0]         long_ticks = LONG_PRESS_RST;
  logic [5:0]         single_tick = SINGLE_LONG_RST;
  logic               key_held = 1'b0;
  logic               rel_pending = 1'b0;
  logic [CODE_W-1:0]  cur_code = '0;
  logic [CODE_W-1:0]  rel_code = '0;
  logic [COUNT_W-1:0] hold_cnt = '0;

  assign quiet = (ticks_taken >= 300) && (ticks_taken < 450);

  keypad_debounce_autorepeat i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_keys_pressed   (in_keys_pressed),
    .in_shift_pressed  (in_shift_pressed),
    .in_lcd_show_state (in_lcd_show_state),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_key_code      (out_key_code),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CODE_W-1:0] scan_code(input logic [NUM_KEYS-1:0] keys,
                                                  input logic shift);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (keys[i]) code = KEY_MAP[i];
    end
    if (code != '0 && shift) code = code | SHIFT_BIT;
    return code;
  endfunction

  // Advance the hold tracker by one scan tick and queue any emitted code
  task automatic step_tick(input logic [NUM_KEYS-1:0] keys, input logic shift,
                           input logic show);
    logic [CODE_W-1:0] code;
    logic              emit;
    logic [OUT_W-1:0]  res;
    code = scan_code(keys, shift);
    emit = 1'b0;
    res = '0;
    if (key_held) begin
      if (code == cur_code) begin
        if (hold_cnt >= CYCLE_HIGH) hold_cnt = CYCLE_LOW;
        else hold_cnt = hold_cnt + 1'b1;
        if (hold_cnt > long_ticks && hold_cnt[1:0] == 2'b00) begin
          if (code >= FUNC_LOW && code <= FUNC_HIGH) begin
            if (!show || hold_cnt == single_tick) begin
              res = {1'b0, code} | LONG_MARK;
              emit = 1'b1;
            end
          end else begin
            res = {1'b0, code};
            emit = 1'b1;
          end
        end
      end else begin
        if (code == '0) begin
          if (hold_cnt >= long_ticks || hold_cnt < min_ticks) begin
            key_held = 1'b0;
          end else begin
            rel_code = cur_code;
            rel_pending = 1'b1;
          end
        end else begin
          cur_code = code;
        end
        hold_cnt = '0;
      end
    end else if (code != '0) begin
      cur_code = code;
      key_held = 1'b1;
      hold_cnt = '0;
    end
    if (key_held && rel_pending && rel_code != '0 && !emit) begin
      key_held = 1'b0;
      rel_pending = 1'b0;
      res = {1'b0, rel_code};
      emit = 1'b1;
    end
    if (emit) code_q.push_back(res);
  endtask

  // Driver: record the accepted transaction, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_tick(in_keys_pressed, in_shift_pressed, in_lcd_show_state);
        ticks_taken <= ticks_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (tick_q.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
          next_tick = tick_q.pop_front();
          in_valid <= 1'b1;
          in_keys_pressed <= next_tick.keys;
          in_shift_pressed <= next_tick.shift;
          in_lcd_show_state <= next_tick.show;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_left != 0) begin
      out_stall <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else if (!hold_off_done && ticks_taken >= 700) begin
      out_stall <= 1'b1;
      hold_off_left <= 250;
      hold_off_done <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 7);
    end
  end

  // Monitor
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      codes_seen <= codes_seen + 1;
      if (code_q.size() == 0) begin
        if (fail_cnt < 10) $display("unexpected key code %h", out_key_code);
        fail_cnt++;
      end else begin
        want = code_q.pop_front();
        if (out_key_code !== want) begin
          if (fail_cnt < 10)
            $display("key code mismatch: expected %h, got %h", want, out_key_code);
          fail_cnt++;
        end
      end
    end
  end

  task automatic push_tick(input logic [NUM_KEYS-1:0] keys, input logic shift,
                           input logic show);
    scan_tick_t t;
    t.keys = keys;
    t.shift = shift;
    t.show = show;
    tick_q.push_back(t);
    ticks_pushed++;
  endtask

  // Random key map whose highest pressed key is at pos
  function automatic logic [NUM_KEYS-1:0] keys_topped(input int unsigned pos);
    logic [NUM_KEYS-1:0] top;
    logic [NUM_KEYS-1:0] low_bits;
    top = 16'h1 << pos;
    low_bits = NUM_KEYS'($urandom);
    return top | (low_bits & (top - 16'h1));
  endfunction

  task automatic push_hold(input int unsigned pos, input logic shift, input logic show_mode,
                           input int unsigned len);
    logic show;
    for (int i = 0; i < len; i++) begin
      show = ($urandom_range(9) == 0) ? !show_mode : show_mode;
      push_tick(keys_topped(pos), shift, show);
    end
  endtask

  task automatic push_release();
    int unsigned n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++)
      push_tick('0, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(1, 17);
    if (r < 85) return $urandom_range(18, 44);
    return $urandom_range(1, 2);
  endfunction

  task automatic push_random(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    int unsigned pos_a;
    int unsigned pos_b;
    logic        shift_a;
    logic        shift_b;
    stop_at = ticks_pushed + n_items;
    // one long hold to walk the count through its wrap
    push_hold($urandom_range(15), 1'($urandom_range(1)), 1'($urandom_range(1)), 40);
    push_release();
    while (ticks_pushed < stop_at) begin
      r = $urandom_range(99);
      pos_a = $urandom_range(15);
      shift_a = ($urandom_range(3) == 0);
      if (r < 70) begin
        push_hold(pos_a, shift_a, 1'($urandom_range(1)), pick_len());
        push_release();
      end else if (r < 85) begin
        // switch to another code while held
        pos_b = $urandom_range(15);
        shift_b = (pos_b == pos_a) ? !shift_a : 1'($urandom_range(1));
        push_hold(pos_a, shift_a, 1'($urandom_range(1)), $urandom_range(1, 12));
        push_hold(pos_b, shift_b, 1'($urandom_range(1)), pick_len());
        push_release();
      end else begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          push_tick(($urandom_range(3) == 0) ? '0 : NUM_KEYS'($urandom),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_PRESS:   min_ticks = data[3:0];
      REG_LONG_PRESS:  long_ticks = data[4:0];
      REG_SINGLE_LONG: single_tick = data[5:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [3:0] min_v, input logic [4:0] long_v,
                               input logic [5:0] single_v);
    logic [CFG_DAT_W-1:0] d;
    // unused upper data bits carry noise
    d = CFG_DAT_W'($urandom);
    d[3:0] = min_v;
    write_reg(REG_MIN_PRESS, d);
    d = CFG_DAT_W'($urandom);
    d[4:0] = long_v;
    write_reg(REG_LONG_PRESS, d);
    write_reg(REG_SINGLE_LONG, single_v);
    settings_cnt++;
  endtask

  // Wait until every tick is taken and every code has left, then let the pipe settle
  task automatic drain();
    do @(posedge clk); while (tick_q.size() != 0 || in_valid || code_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // walk every key alone, then all keys shifted and a valid release
    push_tick('0, 1'b0, 1'b0);
    for (int i = 0; i < NUM_KEYS; i++) push_tick(16'h1 << i, i[0], i[1]);
    push_tick(16'hFFFF, 1'b1, 1'b0);
    push_tick(16'hFFFF, 1'b1, 1'b1);
    push_tick(16'hFFFF, 1'b1, 1'b0);
    push_tick('0, 1'b1, 1'b1);
    push_tick('0, 1'b0, 1'b0);
    push_random(150);
    drain();

    apply_setting(4'd1, 5'd4, 6'd4);
    push_random(150);
    drain();

    apply_setting(4'd15, 5'd31, 6'd32);
    push_random(150);
    drain();

    // zero minimum, tiny long threshold, single long tick never reached
    apply_setting(4'd0, 5'd2, 6'd63);
    push_random(150);
    drain();

    apply_setting(4'($urandom_range(1, 15)), 5'($urandom_range(4, 31)),
                  6'($urandom_range(4, 32)));
    push_random(150);
    drain();

    apply_setting(4'($urandom), 5'($urandom), 6'($urandom));
    push_random(150);

    do @(posedge clk); while (tick_q.size() != 0 || in_valid);
    waited = 0;
    while (code_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (code_q.size() != 0) begin
      if (fail_cnt < 10) $display("%0d key codes never emitted", code_q.size());
      fail_cnt++;
    end

    $display("Scanned %0d ticks under %0d register settings; %0d key codes checked, %0d failures.",
             ticks_taken, settings_cnt, codes_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d ticks taken.", ticks_taken);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
